[design/sra_pkg.sv]
// Shared definitions for the stack region allocator: default sizes,
// result status codes, configuration register indexes and record constants.
// No dependencies.
`default_nettype none

package sra_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 256;
	localparam int unsigned ADDR_WIDTH_DEF  = 32;

	localparam int unsigned RECORD_BYTES = 4;
	localparam int unsigned ALIGN_MASK   = 3;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_ROOM    = 3'd1,
		ST_STACK_FULL = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_NOT_LAST   = 3'd4
	} status_t;

	typedef enum logic {
		CFG_HEAP_START = 1'b0,
		CFG_HEAP_END   = 1'b1
	} cfg_index_t;

endpackage

`default_nettype wire

[design/stack_region_allocator.sv]
// Stack region allocator: bump allocation with LIFO release over one address region.
// A taken input beat waits in the stage-1 registers until its result can be written
// to the output register. Throughput: one request per cycle while the output result
// is not stalled; the block-start stack is a memory with one write and one registered
// read port, with the top two entries kept in registers. Reset clears the region end
// bound, the next free address and the stack count; the stack memory itself is not cleared.
`default_nettype none

module stack_region_allocator #(
	parameter int unsigned STACK_DEPTH = sra_pkg::STACK_DEPTH_DEF,
	parameter int unsigned ADDR_WIDTH  = sra_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [31:0] alloc_size,
	input  wire logic [31:0] free_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic [2:0]       status,
	output logic [31:0]      block_address,
	output logic [31:0]      free_bytes
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned EW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 2;

	typedef logic [ADDR_WIDTH-1:0] addr_t;
	typedef logic [EW-1:0] wide_t;

	addr_t heap_end_q;
	addr_t free_ptr_q;
	logic [CW-1:0] count_q;
	addr_t top_q;
	addr_t second_q;
	addr_t stack_mem [STACK_DEPTH];

	logic        valid_s1;
	logic        operation_s1;
	logic [31:0] alloc_size_s1;
	logic [31:0] free_address_s1;

	logic               out_valid_q;
	logic               ok_q;
	sra_pkg::status_t   status_q;
	logic [31:0]        block_address_q;
	logic [31:0]        free_bytes_q;

	logic               advance;
	logic               start_wr;
	wide_t              next_w;
	logic               room;
	logic               full;
	logic               empty;
	logic               match;
	logic               push;
	logic               pop;
	addr_t              free_ptr_new;
	sra_pkg::status_t   status_new;
	wide_t              need_w;
	wide_t              left_w;
	logic [31:0]        free_new;
	logic [CW-1:0]      count_m3;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign start_wr = cfg_we && (cfg_index == sra_pkg::CFG_HEAP_START);

	assign next_w = ((EW'(free_ptr_q) + EW'(alloc_size_s1) + EW'(sra_pkg::ALIGN_MASK))
		& ~EW'(sra_pkg::ALIGN_MASK)) + EW'(sra_pkg::RECORD_BYTES);
	assign room  = next_w <= EW'(heap_end_q);
	assign full  = count_q == CW'(STACK_DEPTH);
	assign empty = count_q == '0;
	assign match = top_q == ADDR_WIDTH'(free_address_s1);
	assign push  = advance && !operation_s1 && room && !full;
	assign pop   = advance && operation_s1 && !empty && match;
	assign count_m3 = count_q - CW'(3);

	always_comb begin
		free_ptr_new = free_ptr_q;
		if (!operation_s1) begin
			if (!room) begin
				status_new = sra_pkg::ST_NO_ROOM;
			end else if (full) begin
				status_new = sra_pkg::ST_STACK_FULL;
			end else begin
				status_new   = sra_pkg::ST_OK;
				free_ptr_new = next_w[ADDR_WIDTH-1:0];
			end
		end else begin
			if (empty) begin
				status_new = sra_pkg::ST_EMPTY;
			end else if (!match) begin
				status_new = sra_pkg::ST_NOT_LAST;
			end else begin
				status_new   = sra_pkg::ST_OK;
				free_ptr_new = top_q;
			end
		end
	end

	assign need_w = EW'(free_ptr_new) + EW'(sra_pkg::RECORD_BYTES);
	assign left_w = EW'(heap_end_q) - need_w;

	always_comb begin
		if (need_w > EW'(heap_end_q)) begin
			free_new = '0;
		end else if (left_w > EW'(32'hFFFF_FFFF)) begin
			free_new = '1;
		end else begin
			free_new = left_w[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_end_q  <= '0;
			free_ptr_q  <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == sra_pkg::CFG_HEAP_END)) begin
				heap_end_q <= ADDR_WIDTH'(cfg_data);
			end
			if (start_wr) begin
				free_ptr_q <= ADDR_WIDTH'(cfg_data);
				count_q    <= '0;
			end else if (advance) begin
				free_ptr_q <= free_ptr_new;
				if (push) begin
					count_q <= count_q + CW'(1);
				end else if (pop) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			operation_s1    <= operation;
			alloc_size_s1   <= alloc_size;
			free_address_s1 <= free_address;
		end
		if (advance) begin
			ok_q            <= status_new == sra_pkg::ST_OK;
			status_q        <= status_new;
			block_address_q <= push ? 32'(free_ptr_q) : '0;
			free_bytes_q    <= free_new;
		end
		if (push) begin
			top_q <= free_ptr_q;
		end else if (pop) begin
			top_q <= second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[count_q[IW-1:0]] <= free_ptr_q;
			second_q                   <= top_q;
		end else if (pop) begin
			second_q <= stack_mem[count_m3[IW-1:0]];
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign status        = status_q;
	assign block_address = block_address_q;
	assign free_bytes    = free_bytes_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !start_wr) |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not raise the stack count");

	a_pop_return: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !start_wr) |=> free_ptr_q == $past(top_q))
		else $error("release did not return to the block start");
`endif

endmodule

`default_nettype wire
